/* rtl/smr_pkg.sv */
`timescale 1ns / 1ps
// Package: shared constants and types for the router, with the fixed-point log2(e) constant.
package smr_pkg;
	localparam int unsigned LOGIT_W = 16;
	localparam int unsigned TOPK_LIMIT = 16;
	localparam int unsigned RANK_W = 4;
	localparam int unsigned TOPK_W = 5;
	localparam int unsigned IDX_OUT_W = 8;
	localparam int unsigned E_W = 17;
	localparam int unsigned PROB_W = 17;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [TOPK_W-1:0] TOPK_RESET = 5'd8;

	typedef enum logic [0:0] {
		REG_TOP_K = 1'b0,
		REG_RENORM = 1'b1
	} reg_idx_t;

	// Request handed from the controller to the divider. The denominator holds
	// the exponent sum of a row of up to 1024 experts.
	typedef struct packed {
		logic        start;
		logic [32:0] num;
		logic [26:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [16:0] quot;
	} div_rsp_t;
endpackage

/* rtl/smr_divider.sv */
`timescale 1ns / 1ps
// Module: radix-2 restoring divider, one quotient bit per cycle.
module smr_divider
	import smr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	// Quotient always fits in 17 bits (numerator <= 65536*den + den/2), so 33 steps
	// with a 34-bit partial remainder are enough.
	logic [33:0] rem_q;
	logic [32:0] num_q;
	logic [26:0] den_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] shifted;
	logic [34:0] diff;

	assign shifted = {rem_q[32:0], num_q[32]};
	assign diff = {1'b0, shifted} - {8'd0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			num_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			num_q <= {num_q[31:0], ~diff[34]};
			rem_q <= diff[34] ? shifted : diff[33:0];
		end
	end

	assign rsp = {done_q, num_q[16:0]};
endmodule

/* rtl/smr_exp_unit.sv */
`timescale 1ns / 1ps
// Module: multi-cycle fixed-point exp(-d) for a Q8.8 difference, one multiply per cycle.
module smr_exp_unit
	import smr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [15:0]       d,
	output logic              done,
	output logic [E_W-1:0]    e
);
	typedef enum logic [2:0] {
		X_IDLE, X_MUL, X_P1, X_P2, X_P3, X_P4, X_FIN
	} xst_t;

	xst_t        st_q;
	logic [32:0] t_q;
	logic [15:0] x_q;
	logic [8:0]  n_q;
	logic [16:0] p_q;
	logic [33:0] prod;
	logic [16:0] pm;
	logic [16:0] coef;

	assign prod = {17'd0, p_q} * {18'd0, x_q};
	assign pm = prod[32:16];

	always_comb begin
		case (st_q)
			X_P1:    coef = 17'd3638;
			X_P2:    coef = 17'd15743;
			X_P3:    coef = 17'd45426;
			X_P4:    coef = 17'd65536;
			default: coef = 17'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= X_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (st_q)
				X_IDLE: if (start) st_q <= X_MUL;
				X_MUL: begin
					n_q <= t_q[32:24];
					x_q <= t_q[23:8];
					p_q <= 17'd630;
					st_q <= X_P1;
				end
				X_P1: begin p_q <= coef - pm; st_q <= X_P2; end
				X_P2: begin p_q <= coef - pm; st_q <= X_P3; end
				X_P3: begin p_q <= coef - pm; st_q <= X_P4; end
				X_P4: begin p_q <= coef - pm; st_q <= X_FIN; end
				X_FIN: begin
					e <= (n_q >= 9'd17) ? '0 : (p_q >> n_q[4:0]);
					done <= 1'b1;
					st_q <= X_IDLE;
				end
				default: st_q <= X_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == X_IDLE && start)
			t_q <= {17'd0, d} * {16'd0, LOG2E_Q16};
	end
endmodule

/* rtl/softmax_topk_expert_router.sv */
`timescale 1ns / 1ps
// Top level: softmax top-k expert router with its sequencer and row memories.
// Usage:
// Logits stream in on s_axis (tdata = logit, tlast = end of row), one per
// cycle while the block loads a row. The request carrying tlast starts the
// row pass; s_axis_tready stays low until every result of the row is taken.
// Passes per row of N stored logits and k choices:
//   exponent pass: one exponent per logit (shared exponent unit, 4 Horner
//   steps), probability pass: one division per logit (one shared
//   bit-serial divider), selection: one scan of the N entries per rank, and
//   with renormalize one more division per choice. One result per request on
//   m_axis follows, k in all, rank order, tlast on the final one.
// Capacity is MAX_EXPERTS; extra logits are dropped and flagged in tuser.
// Reset clears the row state and sets top_k to 8, renormalize to 0. The
// chosen flags ride as a spare bit of the probability store, which every
// row rewrites before selection, so they never need a clearing pass.
// If the receiver stalls, the held result waits in the output register and
// the sequencer waits. Configuration writes are taken at any edge with cfg_we high.
module softmax_topk_expert_router
	import smr_pkg::*;
#(
	parameter int unsigned MAX_EXPERTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] logit
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] expert_index, [23:8] weight, [27:24] rank, zero fill
	output logic        m_axis_tuser,   // [0] overflow
	output logic        m_axis_tlast,   // final_res
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [4:0]  cfg_data
);
	localparam int unsigned AW = $clog2(MAX_EXPERTS);
	localparam int unsigned CW = $clog2(MAX_EXPERTS + 1);
	localparam logic [CW-1:0] CAP = CW'(MAX_EXPERTS);

	typedef enum logic [3:0] {
		S_LOAD, S_EXP_RD, S_EXP_GO, S_EXP_WT, S_PR_RD, S_PR_GO, S_PR_WT,
		S_SEL, S_SEL_END, S_RN_RD, S_RN_WT, S_EMIT, S_EMIT_WT
	} st_t;

	st_t                 st_q;
	logic [TOPK_W-1:0]   top_k_q;
	logic                renorm_q;
	logic [CW-1:0]       count_q;
	logic signed [15:0]  max_q;
	logic                drop_q;
	logic [CW-1:0]       i_q;
	logic [26:0]         sum_q;
	logic [PROB_W:0]     den_q;
	logic [4:0]          k_q;
	logic [4:0]          r_q;
	logic [AW-1:0]       best_q;
	logic [PROB_W:0]     bestv_q;
	logic [AW-1:0]       pick_q [TOPK_LIMIT];
	logic [16:0]         pickv_q [TOPK_LIMIT];

	// Row memories: logits, then exponents and probabilities share one store.
	// Bit 17 of the probability store marks an expert already chosen.
	logic [15:0]         lmem [MAX_EXPERTS];
	logic [17:0]         pmem [MAX_EXPERTS];
	logic [15:0]         lrd_q;
	logic [17:0]         prd_q;
	logic [AW-1:0]       prd_addr_q;
	logic                pwe;
	logic [AW-1:0]       pwa;
	logic [17:0]         pwd;

	logic                x_start, x_done;
	logic [16:0]         x_e;
	div_req_t            dreq;
	div_rsp_t            drsp;
	logic [4:0]          k_eff;
	logic [AW-1:0]       i_idx;
	logic [16:0]         w_out;

	assign i_idx = i_q[AW-1:0];
	assign s_axis_tready = (st_q == S_LOAD);

	always_comb begin
		k_eff = (top_k_q == '0) ? 5'd1 : ((top_k_q > 5'd16) ? 5'd16 : top_k_q);
		if (32'(k_eff) > 32'(count_q))
			k_eff = 5'(count_q);
	end

	smr_exp_unit u_exp (
		.clk(clk), .arst_n(arst_n), .start(x_start),
		.d(16'(max_q - $signed(lrd_q))), .done(x_done), .e(x_e)
	);
	smr_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		x_start = (st_q == S_EXP_GO);
		dreq.start = 1'b0;
		dreq.num = {prd_q[16:0], 16'd0} + 33'(sum_q >> 1);
		dreq.den = sum_q;
		if (st_q == S_PR_GO)
			dreq.start = 1'b1;
		if (st_q == S_RN_RD) begin
			dreq.start = 1'b1;
			dreq.num = {pickv_q[r_q[3:0]], 16'd0} + 33'(den_q >> 1);
			dreq.den = 27'(den_q);
		end
		pwe = 1'b0;
		pwa = i_idx;
		pwd = {1'b0, x_e};
		if (st_q == S_EXP_WT && x_done)
			pwe = 1'b1;
		if (st_q == S_PR_WT && drsp.done) begin
			pwe = 1'b1;
			pwd = {1'b0, drsp.quot};
		end
		// Mark the winner of this rank so later scans skip it.
		if (st_q == S_SEL_END) begin
			pwe = 1'b1;
			pwa = best_q;
			pwd = {1'b1, bestv_q[16:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready && count_q < CAP)
			lmem[count_q[AW-1:0]] <= s_axis_tdata;
		lrd_q <= lmem[i_idx];
		if (pwe)
			pmem[pwa] <= pwd;
		prd_q <= pmem[i_idx];
		prd_addr_q <= i_idx;
	end

	assign w_out = renorm_q ? drsp.quot : pickv_q[r_q[3:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD;
			top_k_q <= TOPK_RESET;
			renorm_q <= 1'b0;
			count_q <= '0;
			max_q <= 16'sh8000;
			drop_q <= 1'b0;
			i_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_TOP_K:  top_k_q <= cfg_data;
					REG_RENORM: renorm_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (st_q)
				S_LOAD: if (s_axis_tvalid) begin
					if (count_q < CAP) begin
						count_q <= count_q + 1'b1;
						if ($signed(s_axis_tdata) > max_q) max_q <= $signed(s_axis_tdata);
					end else
						drop_q <= 1'b1;
					if (s_axis_tlast) begin
						i_q <= '0;
						sum_q <= '0;
						st_q <= S_EXP_RD;
					end
				end
				S_EXP_RD: st_q <= S_EXP_GO;
				S_EXP_GO: st_q <= S_EXP_WT;
				S_EXP_WT: if (x_done) begin
					sum_q <= sum_q + 27'(x_e);
					if (i_q + 1'b1 == count_q) begin
						i_q <= '0;
						st_q <= S_PR_RD;
					end else begin
						i_q <= i_q + 1'b1;
						st_q <= S_EXP_RD;
					end
				end
				S_PR_RD: st_q <= S_PR_GO;
				S_PR_GO: st_q <= S_PR_WT;
				S_PR_WT: if (drsp.done) begin
					if (i_q + 1'b1 == count_q) begin
						i_q <= '0;
						k_q <= k_eff;
						r_q <= '0;
						den_q <= '0;
						bestv_q <= '1;
						st_q <= S_SEL;
					end else begin
						i_q <= i_q + 1'b1;
						st_q <= S_PR_RD;
					end
				end
				// Scan: address i issued, data of i-1 arrives in prd_q.
				S_SEL: begin
					if (i_q != '0 && !prd_q[17] &&
					    (bestv_q[PROB_W] || {1'b0, prd_q[16:0]} > bestv_q)) begin
						bestv_q <= {1'b0, prd_q[16:0]};
						best_q <= prd_addr_q;
					end
					if (i_q == count_q) st_q <= S_SEL_END;
					else i_q <= i_q + 1'b1;
				end
				S_SEL_END: begin
					pick_q[r_q[3:0]] <= best_q;
					pickv_q[r_q[3:0]] <= bestv_q[16:0];
					den_q <= den_q + bestv_q;
					bestv_q <= '1;
					i_q <= '0;
					if (r_q + 1'b1 == k_q) begin
						r_q <= '0;
						st_q <= renorm_q ? S_RN_RD : S_EMIT;
					end else begin
						r_q <= r_q + 1'b1;
						st_q <= S_SEL;
					end
				end
				S_RN_RD: st_q <= S_RN_WT;
				S_RN_WT: if (drsp.done) st_q <= S_EMIT;
				S_EMIT: begin
					m_axis_tvalid <= 1'b1;
					m_axis_tdata <= {4'd0, r_q[3:0],
						(w_out[16] ? 16'hFFFF : w_out[15:0]),
						IDX_OUT_W'(pick_q[r_q[3:0]])};
					m_axis_tuser <= drop_q;
					m_axis_tlast <= (r_q + 1'b1 == k_q);
					st_q <= S_EMIT_WT;
				end
				S_EMIT_WT: if (m_axis_tready) begin
					m_axis_tvalid <= 1'b0;
					if (m_axis_tlast) begin
						count_q <= '0;
						max_q <= 16'sh8000;
						drop_q <= 1'b0;
						i_q <= '0;
						st_q <= S_LOAD;
					end else begin
						r_q <= r_q + 1'b1;
						st_q <= renorm_q ? S_RN_RD : S_EMIT;
					end
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CAP)
		else $error("row count beyond capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("loading while a result is pending");
endmodule

/* sim/tb_softmax_topk_expert_router.sv */
`timescale 1ns / 1ps
// Testbench: self-checking stimulus and result checks for the softmax top-k expert router.
module tb_softmax_topk_expert_router
	import smr_pkg::*;
();

	localparam int NUM_EXPERTS = 256;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 60;

	// One routing choice as the block reports it.
	typedef struct {
		logic [7:0]  expert_index;
		logic [15:0] weight;
		logic [3:0]  rank;
		logic        overflow;
		logic        final_res;
	} choice_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [15:0] logit
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [7:0] expert_index, [23:8] weight, [27:24] rank
	logic        m_axis_tuser;   // [0] overflow
	logic        m_axis_tlast;   // final_res
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [4:0]  cfg_data;

	// Model state: the row being loaded and the active register settings.
	logic signed [15:0] row_logits[$];
	logic signed [15:0] row_max;
	logic               row_dropped;
	logic [TOPK_W-1:0]  cur_top_k;
	logic               cur_renorm;

	choice_t pending_choices[$];
	int      errors;
	int      cycles;
	bit      idle_en;
	int      hold_cycles;

	softmax_topk_expert_router #(.MAX_EXPERTS(NUM_EXPERTS)) dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// Fixed-point exp(-d) for a Q8.8 distance, result Q16 with 1.0 = 65536.
	function automatic longint unsigned exp_neg(input longint unsigned d);
		longint unsigned t, n, x, p;
		t = d * 94548;
		n = t >> 24;
		x = (t >> 8) & 64'hFFFF;
		p = 630;
		p = 3638 - ((p * x) >> 16);
		p = 15743 - ((p * x) >> 16);
		p = 45426 - ((p * x) >> 16);
		p = 65536 - ((p * x) >> 16);
		if (n >= 17)
			return 0;
		return p >> n;
	endfunction

	// Softmax over the loaded row, greedy top-k, then queue the choices.
	task automatic route_row();
		longint unsigned prob[];
		bit              taken[];
		int              pick[16];
		longint unsigned total, den, w, best_v;
		int              n, k, best;
		choice_t         c;
		n = row_logits.size();
		prob = new[n];
		taken = new[n];
		total = 0;
		for (int i = 0; i < n; i++) begin
			prob[i] = exp_neg(longint'(int'(row_max) - int'(row_logits[i])));
			total += prob[i];
			taken[i] = 1'b0;
		end
		if (total == 0)
			total = 1;
		for (int i = 0; i < n; i++)
			prob[i] = (prob[i] * 65536 + total / 2) / total;
		k = (cur_top_k == 0) ? 1 : int'(cur_top_k);
		if (k > 16)
			k = 16;
		if (k > n)
			k = n;
		den = 0;
		for (int r = 0; r < k; r++) begin
			best = -1;
			best_v = 0;
			for (int i = 0; i < n; i++) begin
				// Strict compare: the lowest index keeps a tie.
				if (!taken[i] && (best < 0 || prob[i] > best_v)) begin
					best = i;
					best_v = prob[i];
				end
			end
			taken[best] = 1'b1;
			pick[r] = best;
			den += prob[best];
		end
		if (den == 0)
			den = 65536;
		for (int r = 0; r < k; r++) begin
			w = prob[pick[r]];
			if (cur_renorm)
				w = (w * 65536 + den / 2) / den;
			if (w > 65535)
				w = 65535;
			c.expert_index = pick[r][7:0];
			c.weight = w[15:0];
			c.rank = r[3:0];
			c.overflow = row_dropped;
			c.final_res = (r + 1 == k);
			pending_choices.push_back(c);
		end
		row_logits.delete();
		row_max = -16'sd32768;
		row_dropped = 1'b0;
	endtask

	// Offer one logit and wait until the block takes the request.
	task automatic send_logit(input logic signed [15:0] logit, input bit last);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= logit;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		if (row_logits.size() < NUM_EXPERTS) begin
			row_logits.push_back(logit);
			if (logit > row_max)
				row_max = logit;
		end else begin
			row_dropped = 1'b1;
		end
		if (last)
			route_row();
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_choices.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Registers only change once the block has finished every row.
	task automatic write_reg(input reg_idx_t idx, input logic [4:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TOP_K)
			cur_top_k = value;
		else
			cur_renorm = value[0];
	endtask

	task automatic send_random_row(input int len, input bit wide);
		logic signed [15:0] v;
		logic signed [15:0] base;
		base = 16'($urandom);
		for (int i = 0; i < len; i++) begin
			// Narrow rows keep many experts with nonzero probability.
			if (wide)
				v = 16'($urandom);
			else
				v = base + $signed(16'($urandom_range(0, 1024)) - 16'sd512);
			send_logit(v, i == len - 1);
		end
	endtask

	// Result checker: compare every accepted result with the oldest expectation.
	always @(posedge clk) begin
		choice_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_choices.size() == 0) begin
				report("results pending", 1, 0);
			end else begin
				want = pending_choices.pop_front();
				if (m_axis_tdata[7:0] !== want.expert_index)
					report("expert_index", m_axis_tdata[7:0], want.expert_index);
				if (m_axis_tdata[23:8] !== want.weight)
					report("weight", m_axis_tdata[23:8], want.weight);
				if (m_axis_tdata[27:24] !== want.rank)
					report("rank", m_axis_tdata[27:24], want.rank);
				if (m_axis_tuser !== want.overflow)
					report("overflow", m_axis_tuser, want.overflow);
				if (m_axis_tlast !== want.final_res)
					report("final_res", m_axis_tlast, want.final_res);
			end
		end
	end

	// Receiver readiness: short random stall bursts, plus one long hold-off.
	int stall_left;
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic test_directed();
		// Single most negative logit: top_k is cut to one expert.
		send_logit(-16'sd32768, 1'b1);
		// Extremes of the logit range in one row.
		send_logit(16'sd32767, 1'b0);
		send_logit(-16'sd32768, 1'b0);
		send_logit(16'sd0, 1'b0);
		send_logit(16'sd1, 1'b0);
		send_logit(-16'sd1, 1'b1);
		// Equal logits: ties go to the lowest index.
		for (int i = 0; i < 4; i++)
			send_logit(16'sd1280, i == 3);
		// top_k of zero acts as one.
		write_reg(REG_TOP_K, 5'd0);
		send_random_row(3, 1'b0);
		// top_k above sixteen is cut to sixteen.
		write_reg(REG_TOP_K, 5'd31);
		send_random_row(17, 1'b0);
		write_reg(REG_RENORM, 5'd1);
		write_reg(REG_TOP_K, 5'd16);
		send_random_row(16, 1'b0);
		write_reg(REG_TOP_K, 5'd1);
		send_random_row(3, 1'b0);
		write_reg(REG_TOP_K, 5'd3);
		send_random_row(6, 1'b1);
	endtask

	task automatic test_capacity();
		// A row longer than the store: the extra logit is dropped and flagged,
		// and its last flag still ends the row.
		write_reg(REG_TOP_K, 5'd4);
		send_random_row(NUM_EXPERTS + 1, 1'b0);
	endtask

	task automatic test_random(input int items);
		int sent, len;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 5) == 0) begin
				write_reg(REG_TOP_K, 5'($urandom_range(0, 31)));
				write_reg(REG_RENORM, 5'($urandom_range(0, 1)));
			end
			len = $urandom_range(1, 12);
			send_random_row(len, $urandom_range(0, 3) == 0);
			sent += len;
		end
	endtask

	task automatic test_backpressure();
		// Hold the receiver off while rows keep arriving so the input stalls.
		write_reg(REG_TOP_K, 5'd8);
		hold_cycles = 2000;
		for (int i = 0; i < 3; i++)
			send_random_row(4, 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		idle_en = 1'b1;
		hold_cycles = 0;
		stall_left = 0;
		cur_top_k = TOPK_RESET;
		cur_renorm = 1'b0;
		row_max = -16'sd32768;
		row_dropped = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_capacity();
		test_random(12);
		test_backpressure();
		// Closing stretch runs without idling on either side.
		drain();
		idle_en = 1'b0;
		test_random(12);
		drain();

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
